[design/csud_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csud_pkg
// shared types, character codes and the escape letter table for the
// c string unescape decoder
// ----------------------------------------------------------------------------
package csud_pkg;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_SEVEN     = 8'h37;

    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_B = 8'h62;
    localparam logic [7:0] CHAR_F = 8'h66;
    localparam logic [7:0] CHAR_N = 8'h6E;
    localparam logic [7:0] CHAR_R = 8'h72;
    localparam logic [7:0] CHAR_T = 8'h74;
    localparam logic [7:0] CHAR_V = 8'h76;

    localparam logic [7:0] CTRL_BEL = 8'h07;
    localparam logic [7:0] CTRL_BS  = 8'h08;
    localparam logic [7:0] CTRL_FF  = 8'h0C;
    localparam logic [7:0] CTRL_LF  = 8'h0A;
    localparam logic [7:0] CTRL_CR  = 8'h0D;
    localparam logic [7:0] CTRL_HT  = 8'h09;
    localparam logic [7:0] CTRL_VT  = 8'h0B;

    // most digits in one octal escape
    localparam logic [1:0] OCTAL_MAX_DIGITS = 2'd3;

    // depth of the result buffer, enough for the two results of one byte
    localparam int unsigned RESULT_DEPTH = 2;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_OCTAL  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
    } result_t;

    function automatic logic is_octal(input logic [7:0] b);
        return b inside {[CHAR_ZERO:CHAR_SEVEN]};
    endfunction

    function automatic logic [7:0] map_escape(input logic [7:0] b);
        logic [7:0] r;
        case (b)
            CHAR_A:  r = CTRL_BEL;
            CHAR_B:  r = CTRL_BS;
            CHAR_F:  r = CTRL_FF;
            CHAR_N:  r = CTRL_LF;
            CHAR_R:  r = CTRL_CR;
            CHAR_T:  r = CTRL_HT;
            CHAR_V:  r = CTRL_VT;
            default: r = b;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[design/c_string_unescape_decoder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c_string_unescape_decoder_unit
// undoes c style escapes on a byte stream, one raw byte per transaction
// ----------------------------------------------------------------------------
// One raw byte is taken per clock unless the input stalls, and gives zero,
// one or two decoded bytes. A backslash followed by a, b, f, n, r, t or v
// gives the matching control byte, a backslash followed by one to three
// octal digits gives their value (low 8 bits), and a backslash followed by
// anything else gives that byte. A byte that ends an octal run first
// releases the octal value and is then decoded afresh, so it gives two
// results; a backslash gives one and opens a new escape. A lone backslash at
// the end of a string yields an end-only marker (has_byte low), and a pending
// octal value is flushed when the string ends. The byte enters an input
// register, one level of decode logic writes its results into a two-entry
// result buffer, and the buffer head drives the output. The input takes a
// transaction every cycle until the buffer lacks room for a byte's results,
// and the output moves one result per cycle while out_stall is low.
module c_string_unescape_decoder_unit
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input channel
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    // output channel
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic      [7:0] out_byte,
    output logic            has_byte,
    output logic            out_last
);

    // input register
    logic       ip_valid_reg, ip_valid_next;
    logic [7:0] ip_byte_reg;
    logic       ip_last_reg;

    // decoder state
    csud_pkg::mode_t mode_reg, mode_next;
    logic [1:0]      count_reg, count_next;
    logic [7:0]      value_reg, value_next;

    // result buffer, slot 0 is the head
    csud_pkg::result_t slot0_reg, slot0_next;
    csud_pkg::result_t slot1_reg, slot1_next;
    logic [1:0]        fill_reg, fill_next;

    // decode of the byte held in the input register
    csud_pkg::result_t res0, res1;
    logic [1:0]        n_res;
    csud_pkg::mode_t   dec_mode;
    logic [1:0]        dec_count;
    logic [7:0]        dec_value;

    logic       pop;
    logic       consume;
    logic       in_accept;
    logic [1:0] remain;
    logic [2:0] need;

    logic [7:0] b;
    logic       last;
    logic [2:0] digit;
    logic [7:0] grown;
    logic [1:0] count_inc;

    assign b         = ip_byte_reg;
    assign last      = ip_last_reg;
    assign digit     = b[2:0];
    assign grown     = {value_reg[4:0], digit};
    assign count_inc = count_reg + 2'd1;

    // ---- decode ------------------------------------------------------------
    always_comb
    begin
        res0      = '{data: 8'd0, has: 1'b0, last: 1'b0};
        res1      = '{data: 8'd0, has: 1'b0, last: 1'b0};
        n_res     = 2'd0;
        dec_mode  = mode_reg;
        dec_count = count_reg;
        dec_value = value_reg;
        case (mode_reg)
            csud_pkg::MODE_ESCAPE:
            begin
                if (csud_pkg::is_octal(b))
                begin
                    if (last)
                    begin
                        res0      = '{data: {5'd0, digit}, has: 1'b1, last: 1'b1};
                        n_res     = 2'd1;
                        dec_mode  = csud_pkg::MODE_NORMAL;
                        dec_count = 2'd0;
                        dec_value = 8'd0;
                    end
                    else
                    begin
                        dec_mode  = csud_pkg::MODE_OCTAL;
                        dec_count = 2'd1;
                        dec_value = {5'd0, digit};
                    end
                end
                else
                begin
                    res0      = '{data: csud_pkg::map_escape(b), has: 1'b1, last: last};
                    n_res     = 2'd1;
                    dec_mode  = csud_pkg::MODE_NORMAL;
                    dec_count = 2'd0;
                    dec_value = 8'd0;
                end
            end
            csud_pkg::MODE_OCTAL:
            begin
                if (csud_pkg::is_octal(b) && (count_reg < csud_pkg::OCTAL_MAX_DIGITS))
                begin
                    if ((count_inc == csud_pkg::OCTAL_MAX_DIGITS) || last)
                    begin
                        res0      = '{data: grown, has: 1'b1, last: last};
                        n_res     = 2'd1;
                        dec_mode  = csud_pkg::MODE_NORMAL;
                        dec_count = 2'd0;
                        dec_value = 8'd0;
                    end
                    else
                    begin
                        dec_count = count_inc;
                        dec_value = grown;
                    end
                end
                else
                begin
                    // run ends: release the value, then the byte goes afresh
                    dec_count = 2'd0;
                    dec_value = 8'd0;
                    dec_mode  = csud_pkg::MODE_NORMAL;
                    if (b == csud_pkg::CHAR_BACKSLASH)
                    begin
                        res0  = '{data: value_reg, has: 1'b1, last: last};
                        n_res = 2'd1;
                        if (!last)
                        begin
                            dec_mode = csud_pkg::MODE_ESCAPE;
                        end
                    end
                    else
                    begin
                        res0  = '{data: value_reg, has: 1'b1, last: 1'b0};
                        res1  = '{data: b, has: 1'b1, last: last};
                        n_res = 2'd2;
                    end
                end
            end
            default:
            begin
                if (b == csud_pkg::CHAR_BACKSLASH)
                begin
                    if (last)
                    begin
                        // trailing lone backslash: end-only marker
                        res0      = '{data: 8'd0, has: 1'b0, last: 1'b1};
                        n_res     = 2'd1;
                        dec_mode  = csud_pkg::MODE_NORMAL;
                        dec_count = 2'd0;
                        dec_value = 8'd0;
                    end
                    else
                    begin
                        dec_mode = csud_pkg::MODE_ESCAPE;
                    end
                end
                else
                begin
                    res0     = '{data: b, has: 1'b1, last: last};
                    n_res    = 2'd1;
                    dec_mode = csud_pkg::MODE_NORMAL;
                    if (last)
                    begin
                        dec_count = 2'd0;
                        dec_value = 8'd0;
                    end
                end
            end
        endcase
    end

    // ---- flow control ------------------------------------------------------
    assign pop       = out_valid && !out_stall;
    assign remain    = fill_reg - {1'b0, pop};
    assign need      = {1'b0, remain} + {1'b0, n_res};
    assign consume   = ip_valid_reg && (need <= 3'(csud_pkg::RESULT_DEPTH));
    assign in_stall  = ip_valid_reg && !consume;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        ip_valid_next = ip_valid_reg;
        if (in_accept)
        begin
            ip_valid_next = 1'b1;
        end
        else if (consume)
        begin
            ip_valid_next = 1'b0;
        end
    end

    // ---- decoder state update ----------------------------------------------
    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        value_next = value_reg;
        if (consume)
        begin
            mode_next  = dec_mode;
            count_next = dec_count;
            value_next = dec_value;
        end
    end

    // ---- result buffer -----------------------------------------------------
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (pop)
        begin
            slot0_next = slot1_reg;
        end
        fill_next = remain;
        if (consume)
        begin
            fill_next = need[1:0];
            case (remain)
                2'd0:
                begin
                    slot0_next = res0;
                    slot1_next = res1;
                end
                2'd1:
                begin
                    slot1_next = res0;
                end
                default:
                begin
                    slot1_next = slot1_reg;
                end
            endcase
        end
    end

    // ---- registers ---------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_valid_reg <= 1'b0;
            mode_reg     <= csud_pkg::MODE_NORMAL;
            count_reg    <= 2'd0;
            value_reg    <= 8'd0;
            fill_reg     <= 2'd0;
        end
        else
        begin
            ip_valid_reg <= ip_valid_next;
            mode_reg     <= mode_next;
            count_reg    <= count_next;
            value_reg    <= value_next;
            fill_reg     <= fill_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ip_byte_reg <= in_byte;
            ip_last_reg <= in_last;
        end
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // ---- outputs -----------------------------------------------------------
    assign out_valid = (fill_reg != 2'd0);
    assign out_byte  = slot0_reg.data;
    assign has_byte  = slot0_reg.has;
    assign out_last  = slot0_reg.last;

    // ---- assertions --------------------------------------------------------
    // buffer never holds more than its depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 2'(csud_pkg::RESULT_DEPTH))
        else $error("result buffer overfilled");

    // an octal run holds one or two digits between items
    a_octal_count: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == csud_pkg::MODE_OCTAL) |-> (count_reg == 2'd1 || count_reg == 2'd2))
        else $error("octal digit count out of step with mode");

    // end of string returns the decoder to its reset state
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && ip_last_reg) |=>
            (mode_reg == csud_pkg::MODE_NORMAL && count_reg == 2'd0 && value_reg == 8'd0))
        else $error("decoder state not cleared after end of string");

    // a full, stalled buffer only takes a byte that gives no result
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 2'd2 && out_stall && consume) |-> (n_res == 2'd0))
        else $error("byte consumed into a full result buffer");

    // a byte with two results leaves two entries behind
    a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && n_res == 2'd2) |=> (fill_reg == 2'd2))
        else $error("second result lost");

endmodule
`default_nettype wire
